### hw/rtl/btsm_pkg.sv
// Package for the Beaver-triple share multiply block: widths, state and command types.
// No dependencies.
package btsm_pkg;
    localparam int CW = 60;
    localparam int PARTIES = 16;
    localparam int PW = 4;
    localparam int CNTW = 5;
    localparam logic [CW-1:0] MOD_RESET = 60'hFFF_FFFF_FFFF_FFFF;

    localparam logic [2:0] SEL_X  = 3'd0;
    localparam logic [2:0] SEL_Y  = 3'd1;
    localparam logic [2:0] SEL_A  = 3'd2;
    localparam logic [2:0] SEL_B  = 3'd3;
    localparam logic [2:0] SEL_C  = 3'd4;
    localparam logic [2:0] SEL_XS = 3'd5;
    localparam logic [2:0] SEL_YS = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED,
        ST_ACC,
        ST_STORE,
        ST_EMIT_LD,
        ST_EMIT_RED,
        ST_MUL_YA,
        ST_MUL_XB,
        ST_MUL_XY,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MS_YA,
        MS_XB,
        MS_XY
    } mul_sel_t;

    typedef struct packed {
        logic     red_start;
        logic     red_in;
        logic     acc;
        logic     emit_load;
        logic     emit_red;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     mul_add;
        logic     clear;
    } cmd_t;

    typedef struct packed {
        logic red_done;
        logic mul_done;
    } sts_t;
endpackage

### hw/rtl/btsm_modmul.sv
// Iterative modular multiplier and reducer, one bit per cycle.
// Depends on btsm_pkg.
module btsm_modmul
    import btsm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          mode_red,
    input  logic [CW-1:0] a,
    input  logic [CW-1:0] b,
    input  logic [CW-1:0] q,
    output logic [CW-1:0] res,
    output logic          done
);
    logic [CW:0]    r_reg, r_next;
    logic [CW-1:0]  a_reg, b_reg;
    logic [5:0]     cnt_reg, cnt_next;
    logic           run_reg, run_next, red_reg;
    logic [CW:0]    dbl, t1, t2, sum;

    always_comb
    begin
        dbl = {r_reg[CW-1:0], 1'b0};
        t1  = (dbl >= {1'b0, q}) ? dbl - {1'b0, q} : dbl;
        if (red_reg)
            sum = dbl | {{CW{1'b0}}, b_reg[CW-1]};
        else
            sum = t1 + (b_reg[CW-1] ? {1'b0, a_reg} : '0);
        t2  = (sum >= {1'b0, q}) ? sum - {1'b0, q} : sum;
        r_next   = r_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (start)
        begin
            r_next   = '0;
            cnt_next = 6'(CW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            r_next   = t2;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
            done    <= run_reg && cnt_reg == 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            red_reg <= mode_red;
        end
        else if (run_reg)
            b_reg <= {b_reg[CW-2:0], 1'b0};
    end

    assign res = r_reg[CW-1:0];
endmodule

### hw/rtl/btsm_datapath.sv
// Datapath: share reduction, masked sums, triple stores and per-party product.
// Depends on btsm_pkg and btsm_modmul.
module btsm_datapath
    import btsm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          cmd,
    output sts_t          sts,
    input  logic [CW-1:0] q,
    input  logic [CW-1:0] x_in,
    input  logic [CW-1:0] y_in,
    input  logic [CW-1:0] a_in,
    input  logic [CW-1:0] b_in,
    input  logic [CW-1:0] c_in,
    input  logic [2:0]    red_sel,
    input  logic [PW-1:0] wr_idx,
    input  logic [PW-1:0] rd_idx,
    output logic [CW-1:0] z
);
    logic [CW-1:0] a_mem [PARTIES];
    logic [CW-1:0] b_mem [PARTIES];
    logic [CW-1:0] c_mem [PARTIES];
    logic [CW-1:0] raw_reg [5];
    logic [CW-1:0] red_reg [7];
    logic [CW-1:0] xs_reg, ys_reg, ra_reg, rb_reg, z_reg;
    logic [CW-1:0] red_src, m_a, m_b, mres;
    logic          mdone;

    function automatic logic [CW-1:0] addm(input logic [CW-1:0] u, input logic [CW-1:0] v,
                                          input logic [CW-1:0] m);
        logic [CW:0] s;
        s = {1'b0, u} + {1'b0, v};
        return (s >= {1'b0, m}) ? CW'(s - {1'b0, m}) : s[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] subm(input logic [CW-1:0] u, input logic [CW-1:0] v,
                                          input logic [CW-1:0] m);
        return (u >= v) ? u - v : u + (m - v);
    endfunction

    always_comb
    begin
        unique case (red_sel)
            SEL_X:   red_src = raw_reg[SEL_X];
            SEL_Y:   red_src = raw_reg[SEL_Y];
            SEL_A:   red_src = raw_reg[SEL_A];
            SEL_B:   red_src = raw_reg[SEL_B];
            SEL_C:   red_src = raw_reg[SEL_C];
            SEL_XS:  red_src = xs_reg;
            SEL_YS:  red_src = ys_reg;
            default: red_src = '0;
        endcase
        m_a = ys_reg;
        m_b = ra_reg;
        unique case (cmd.mul_sel)
            MS_YA: begin m_a = ys_reg; m_b = ra_reg; end
            MS_XB: begin m_a = xs_reg; m_b = rb_reg; end
            MS_XY: begin m_a = xs_reg; m_b = ys_reg; end
            default: begin m_a = ys_reg; m_b = ra_reg; end
        endcase
        if (cmd.red_start)
            m_b = red_src;
    end

    btsm_modmul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.red_start || cmd.mul_start),
        .mode_red (cmd.red_start),
        .a        (m_a),
        .b        (m_b),
        .q        (q),
        .res      (mres),
        .done     (mdone)
    );

    assign sts.red_done = mdone;
    assign sts.mul_done = mdone;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xs_reg <= '0;
            ys_reg <= '0;
        end
        else if (cmd.clear)
        begin
            xs_reg <= '0;
            ys_reg <= '0;
        end
        else if (cmd.acc)
        begin
            xs_reg <= addm(red_reg[SEL_XS], subm(red_reg[SEL_X], red_reg[SEL_A], q), q);
            ys_reg <= addm(red_reg[SEL_YS], subm(red_reg[SEL_Y], red_reg[SEL_B], q), q);
        end
        else if (cmd.emit_red && mdone && red_sel == SEL_X)
            xs_reg <= mres;
        else if (cmd.emit_red && mdone && red_sel == SEL_Y)
            ys_reg <= mres;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.red_in)
        begin
            raw_reg[SEL_X] <= x_in;
            raw_reg[SEL_Y] <= y_in;
            raw_reg[SEL_A] <= a_in;
            raw_reg[SEL_B] <= b_in;
            raw_reg[SEL_C] <= c_in;
        end
        if (cmd.emit_load)
        begin
            raw_reg[SEL_X] <= xs_reg;
            raw_reg[SEL_Y] <= ys_reg;
            raw_reg[SEL_A] <= a_mem[rd_idx];
            raw_reg[SEL_B] <= b_mem[rd_idx];
            raw_reg[SEL_C] <= c_mem[rd_idx];
        end
        if (mdone && !cmd.mul_add)
        begin
            red_reg[red_sel] <= mres;
            if (cmd.emit_red)
            begin
                if (red_sel == SEL_A) ra_reg <= mres;
                if (red_sel == SEL_B) rb_reg <= mres;
                if (red_sel == SEL_C) z_reg  <= mres;
            end
        end
        if (mdone && cmd.mul_add)
            z_reg <= addm(z_reg, mres, q);
        if (cmd.acc)
        begin
            a_mem[wr_idx] <= red_reg[SEL_A];
            b_mem[wr_idx] <= red_reg[SEL_B];
            c_mem[wr_idx] <= red_reg[SEL_C];
        end
    end

    assign z = z_reg;
endmodule

### hw/rtl/btsm_ctrl.sv
// Controller state machine: load sequencing, emission loop and result strobe.
// Depends on btsm_pkg.
module btsm_ctrl
    import btsm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          last_party,
    output logic          busy,
    output cmd_t          cmd,
    input  sts_t          sts,
    output logic [2:0]    red_sel,
    output logic [PW-1:0] wr_idx,
    output logic [PW-1:0] rd_idx,
    output logic          done,
    output logic [PW-1:0] party_index,
    output logic          last_result,
    output logic          overflow
);
    state_t        state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next, idx_reg, idx_next;
    logic [2:0]    sel_reg, sel_next;
    logic          last_reg, last_next, ovf_reg, ovf_next, drop_reg, drop_next;
    logic          pend_reg, pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            sel_reg   <= '0;
            last_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            drop_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            sel_reg   <= sel_next;
            last_reg  <= last_next;
            ovf_reg   <= ovf_next;
            drop_reg  <= drop_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        sel_next   = sel_reg;
        last_next  = last_reg;
        ovf_next   = ovf_reg;
        drop_next  = drop_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        cmd.mul_sel = MS_YA;
        busy       = state_reg != ST_IDLE;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    last_next = last_party;
                    drop_next = cnt_reg >= CNTW'(PARTIES);
                    if (cnt_reg >= CNTW'(PARTIES))
                        ovf_next = 1'b1;
                    cmd.red_in = 1'b1;
                    sel_next   = SEL_X;
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                if (drop_reg)
                begin
                    state_next = last_reg ? ST_EMIT_LD : ST_IDLE;
                    idx_next   = '0;
                end
                else
                begin
                    cmd.red_start = 1'b1;
                    state_next    = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (sts.red_done)
                begin
                    if (sel_reg == SEL_YS)
                        state_next = ST_STORE;
                    else
                    begin
                        sel_next   = sel_reg + 3'd1;
                        state_next = ST_RED;
                    end
                end
            end
            ST_STORE:
            begin
                cmd.acc    = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                idx_next   = '0;
                state_next = last_reg ? ST_EMIT_LD : ST_IDLE;
            end
            ST_EMIT_LD:
            begin
                cmd.emit_load = 1'b1;
                sel_next      = SEL_X;
                state_next    = ST_EMIT_RED;
            end
            ST_EMIT_RED:
            begin
                cmd.emit_red = 1'b1;
                if (!pend_reg)
                begin
                    cmd.red_start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (sts.red_done)
                begin
                    pend_next = 1'b0;
                    if (sel_reg == SEL_C)
                        state_next = ST_MUL_YA;
                    else
                        sel_next = sel_reg + 3'd1;
                end
            end
            ST_MUL_YA:
            begin
                cmd.mul_sel = MS_YA;
                cmd.mul_add = 1'b1;
                if (!pend_reg)
                begin
                    cmd.mul_start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (sts.mul_done)
                begin
                    pend_next  = 1'b0;
                    state_next = ST_MUL_XB;
                end
            end
            ST_MUL_XB:
            begin
                cmd.mul_sel = MS_XB;
                cmd.mul_add = 1'b1;
                if (!pend_reg)
                begin
                    cmd.mul_start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (sts.mul_done)
                begin
                    pend_next  = 1'b0;
                    state_next = (idx_reg == '0) ? ST_MUL_XY : ST_OUT;
                end
            end
            ST_MUL_XY:
            begin
                cmd.mul_sel = MS_XY;
                cmd.mul_add = 1'b1;
                if (!pend_reg)
                begin
                    cmd.mul_start = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (sts.mul_done)
                begin
                    pend_next  = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                done = 1'b1;
                if (idx_reg + 1'b1 >= cnt_reg)
                begin
                    cmd.clear  = 1'b1;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_EMIT_LD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // first cycle of each reduction step kicks the unit; hold until done
    assign red_sel     = sel_reg;
    assign wr_idx      = cnt_reg[PW-1:0];
    assign rd_idx      = idx_reg[PW-1:0];
    assign party_index = idx_reg[PW-1:0];
    assign last_result = idx_reg + 1'b1 >= cnt_reg;
    assign overflow    = ovf_reg;
endmodule

### hw/rtl/beaver_triple_share_multiply_core.sv
// Top level of the Beaver-triple share multiply block.
// Depends on btsm_pkg, btsm_ctrl and btsm_datapath.
//
// An item is taken when start is high and busy low. Its five shares and the two running
// masked sums are reduced modulo q by one bit-serial unit, one value after another; an
// item that comes when all party slots are full is dropped and sets overflow. After the
// item marked last_party the block emits one product share per stored party, in party
// order: each share takes five reductions and two modular multiplies on the same unit
// (three for party 0). Each result is shown for one cycle with done high and cannot be
// held off; busy stays high until the last share has gone.
module beaver_triple_share_multiply_core
    import btsm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          modulus_we,
    input  logic [CW-1:0] modulus_wdata,
    input  logic [CW-1:0] x_share,
    input  logic [CW-1:0] y_share,
    input  logic [CW-1:0] a_share,
    input  logic [CW-1:0] b_share,
    input  logic [CW-1:0] c_share,
    input  logic          last_party,
    output logic          done,
    output logic [CW-1:0] z_share,
    output logic [PW-1:0] party_index,
    output logic          last_result,
    output logic          overflow
);
    logic [CW-1:0] mod_reg, q;
    cmd_t          cmd;
    sts_t          sts;
    logic [2:0]    red_sel;
    logic [PW-1:0] wr_idx, rd_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= MOD_RESET;
        else if (modulus_we)
            mod_reg <= modulus_wdata;
    end

    assign q = (mod_reg == '0) ? CW'(1) : mod_reg;

    btsm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .last_party  (last_party),
        .busy        (busy),
        .cmd         (cmd),
        .sts         (sts),
        .red_sel     (red_sel),
        .wr_idx      (wr_idx),
        .rd_idx      (rd_idx),
        .done        (done),
        .party_index (party_index),
        .last_result (last_result),
        .overflow    (overflow)
    );

    btsm_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .q       (q),
        .x_in    (x_share),
        .y_in    (y_share),
        .a_in    (a_share),
        .b_in    (b_share),
        .c_in    (c_share),
        .red_sel (red_sel),
        .wr_idx  (wr_idx),
        .rd_idx  (rd_idx),
        .z       (z_share)
    );
endmodule

### hw/rtl/btsm_checker.sv
// Port-level checker for the share multiply block, bound to the top level.
// Depends on btsm_pkg.
module btsm_checker
    import btsm_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input logic          last_result
);
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result while idle");
    a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
        done && last_result |=> !busy)
        else $error("busy after last result");
    a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("back-to-back results");
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> !done)
        else $error("result on accept");
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item not taken");
endmodule

bind beaver_triple_share_multiply_core btsm_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .last_result (last_result)
);
